// ===== rtl/pdu_pkg.sv =====
package pdu_pkg;

	// Field widths of the request and response channels
	localparam int OPCODE_W = 3;
	localparam int SLOT_W   = 4;
	localparam int PERIOD_W = 16;
	localparam int STATUS_W = 2;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD      = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_ENABLE   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DISABLE  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_SETPER   = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_DISPATCH = 3'd6;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd2;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [STATUS_W-1:0] status_t;

endpackage

// ===== rtl/pdu_req_if.sv =====
interface pdu_req_if;
	logic              valid;
	logic              ready;
	pdu_pkg::opcode_t  opcode;
	pdu_pkg::slot_t    slot;
	pdu_pkg::period_t  period;

	modport source(output valid, output opcode, output slot, output period, input ready);
	modport sink(input valid, input opcode, input slot, input period, output ready);
endinterface

// ===== rtl/pdu_rsp_if.sv =====
interface pdu_rsp_if;
	logic              valid;
	logic              ready;
	pdu_pkg::status_t  status;
	logic              run_valid;
	pdu_pkg::slot_t    run_slot;

	modport source(output valid, output status, output run_valid, output run_slot, input ready);
	modport sink(input valid, input status, input run_valid, input run_slot, output ready);
endinterface

// ===== rtl/periodic_task_dispatcher_unit.sv =====
// Periodic task dispatcher: a table of NUM_SLOTS task slots, slot number is
// priority (lower wins). Requests arrive on req (valid/ready, opcode, slot,
// period); every request yields exactly one response on rsp (status,
// run_valid, run_slot). req.ready is high only while the sequencer is idle.
// Add, remove, enable, disable, set period and unused opcodes go from
// acceptance straight to the finish state. A tick sweeps all slots through
// the countdown memory and the shared decrement unit, one slot per cycle.
// A dispatch scans the flags one slot per cycle from slot 0 and stops at
// the first runnable slot. The response sits in an output register; a new
// request is accepted while it waits. If the receiver stalls, the next
// finished response holds in the sequencer until the output register is
// free. Reset clears every slot's present, enabled and ready flags and
// drops any pending response; period and countdown storage needs no
// clearing since it is used only for present slots, and a successful add
// writes it.
module periodic_task_dispatcher_unit #(
	parameter int NUM_SLOTS   = 16,
	parameter int PERIOD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	pdu_req_if.sink     req,
	pdu_rsp_if.source   rsp
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int CMP_W = (IDX_W > pdu_pkg::SLOT_W) ? IDX_W + 1 : pdu_pkg::SLOT_W + 1;
	localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);

	// Sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_TICK   = 2'd1;
	localparam logic [1:0] S_DISP   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]           state_q;
	logic [NUM_SLOTS-1:0] present_q;
	logic [NUM_SLOTS-1:0] enabled_q;
	logic [NUM_SLOTS-1:0] ready_q;

	// Tick sweep: read pointer and the write-back stage
	logic [CNT_W-1:0]     rd_cnt_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;

	// Dispatch scan pointer
	logic [IDX_W-1:0]     k_q;

	// Result waiting for the output register
	pdu_pkg::status_t     res_status_q;
	logic                 res_run_valid_q;
	pdu_pkg::slot_t       res_run_slot_q;

	// Output register
	logic                 rsp_valid_q;
	pdu_pkg::status_t     rsp_status_q;
	logic                 rsp_run_valid_q;
	pdu_pkg::slot_t       rsp_run_slot_q;

	logic                 accept;
	logic                 inr;
	logic [IDX_W-1:0]     slot_idx;
	logic [PERIOD_BITS-1:0] per_in;
	logic                 out_load;
	pdu_pkg::status_t     add_status;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_wa;
	logic [2*PERIOD_BITS-1:0] mem_wd;
	logic                 mem_re;
	logic [2*PERIOD_BITS-1:0] mem_rd;

	logic                 alu_en;
	logic                 alu_wr;
	logic                 alu_fire;
	logic [PERIOD_BITS-1:0] alu_nxt;
	logic [PERIOD_BITS-1:0] rd_per;
	logic [PERIOD_BITS-1:0] rd_cnt;

	always_comb begin
		req.ready  = (state_q == S_IDLE);
		accept     = req.valid && req.ready;
		inr        = CMP_W'(req.slot) < CMP_W'(NUM_SLOTS);
		slot_idx   = IDX_W'(req.slot);
		per_in     = PERIOD_BITS'(req.period);
		out_load   = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);
		// Add fails on a slot past the table, then on an occupied one
		add_status = !inr ? pdu_pkg::STATUS_RANGE :
			(present_q[slot_idx] ? pdu_pkg::STATUS_BUSY : pdu_pkg::STATUS_OK);
	end

	assign rd_per = mem_rd[2*PERIOD_BITS-1:PERIOD_BITS];
	assign rd_cnt = mem_rd[PERIOD_BITS-1:0];
	assign alu_en = vld_s1 && present_q[idx_s1] && enabled_q[idx_s1];

	pdu_alu #(
		.PERIOD_BITS(PERIOD_BITS)
	) u_alu (
		.en   (alu_en),
		.cnt  (rd_cnt),
		.per  (rd_per),
		.wr   (alu_wr),
		.fire (alu_fire),
		.nxt  (alu_nxt)
	);

	// Memory port: the write-back stage owns it during a tick, the request
	// decode owns it at acceptance of add and set period
	always_comb begin
		mem_re = (state_q == S_TICK) && (rd_cnt_q != SWEEP_END);
		if (state_q == S_TICK) begin
			mem_we = alu_wr;
			mem_wa = idx_s1;
			mem_wd = {rd_per, alu_nxt};
		end else begin
			mem_we = accept && inr &&
				(((req.opcode == pdu_pkg::OP_ADD) && !present_q[slot_idx]) ||
				 (req.opcode == pdu_pkg::OP_SETPER));
			mem_wa = slot_idx;
			mem_wd = {per_in, per_in};
		end
	end

	pdu_cnt_mem #(
		.NUM_SLOTS   (NUM_SLOTS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_cnt_mem (
		.clk (clk),
		.we  (mem_we),
		.wa  (mem_wa),
		.wd  (mem_wd),
		.re  (mem_re),
		.ra  (rd_cnt_q[IDX_W-1:0]),
		.rd  (mem_rd)
	);

	// Sequencer and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			present_q       <= '0;
			enabled_q       <= '0;
			ready_q         <= '0;
			rd_cnt_q        <= '0;
			vld_s1          <= 1'b0;
			idx_s1          <= '0;
			k_q             <= '0;
			res_status_q    <= pdu_pkg::STATUS_OK;
			res_run_valid_q <= 1'b0;
			res_run_slot_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						res_status_q    <= (req.opcode == pdu_pkg::OP_ADD) ? add_status :
							pdu_pkg::STATUS_OK;
						res_run_valid_q <= 1'b0;
						res_run_slot_q  <= '0;
						rd_cnt_q        <= '0;
						k_q             <= '0;
						unique case (req.opcode)
							pdu_pkg::OP_TICK: begin
								state_q <= S_TICK;
							end
							pdu_pkg::OP_ADD: begin
								state_q <= S_FINISH;
								if (inr && !present_q[slot_idx]) begin
									present_q[slot_idx] <= 1'b1;
									enabled_q[slot_idx] <= 1'b1;
									ready_q[slot_idx]   <= 1'b0;
								end
							end
							pdu_pkg::OP_REMOVE: begin
								state_q <= S_FINISH;
								if (inr) begin
									present_q[slot_idx] <= 1'b0;
									enabled_q[slot_idx] <= 1'b0;
									ready_q[slot_idx]   <= 1'b0;
								end
							end
							pdu_pkg::OP_ENABLE: begin
								state_q <= S_FINISH;
								if (inr) begin
									enabled_q[slot_idx] <= 1'b1;
								end
							end
							pdu_pkg::OP_DISABLE: begin
								state_q <= S_FINISH;
								if (inr) begin
									enabled_q[slot_idx] <= 1'b0;
								end
							end
							pdu_pkg::OP_DISPATCH: begin
								state_q <= S_DISP;
							end
							default: begin
								// set period touches only the memory; unused code is a no-op
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_TICK: begin
					// Advance the read pointer; the slot read last cycle writes back now
					if (rd_cnt_q != SWEEP_END) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					vld_s1 <= (rd_cnt_q != SWEEP_END);
					idx_s1 <= rd_cnt_q[IDX_W-1:0];
					if (alu_fire) begin
						ready_q[idx_s1] <= 1'b1;
					end
					if ((rd_cnt_q == SWEEP_END) && !vld_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_DISP: begin
					// Scan from the highest priority slot; stop at the first runnable one
					if (present_q[k_q] && enabled_q[k_q] && ready_q[k_q]) begin
						ready_q[k_q]    <= 1'b0;
						res_run_valid_q <= 1'b1;
						res_run_slot_q  <= pdu_pkg::SLOT_W'(k_q);
						state_q         <= S_FINISH;
					end else if (k_q == LAST_IDX) begin
						state_q <= S_FINISH;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_FINISH: begin
					// Hold the result until the output register frees up
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q    <= res_status_q;
			rsp_run_valid_q <= res_run_valid_q;
			rsp_run_slot_q  <= res_run_slot_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.run_valid = rsp_run_valid_q;
	assign rsp.run_slot  = rsp_run_slot_q;

endmodule

// ===== rtl/pdu_cnt_mem.sv =====
module pdu_cnt_mem #(
	parameter int NUM_SLOTS   = 16,
	parameter int PERIOD_BITS = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(NUM_SLOTS)-1:0] wa,
	input  logic [2*PERIOD_BITS-1:0]   wd,
	input  logic                       re,
	input  logic [$clog2(NUM_SLOTS)-1:0] ra,
	output logic [2*PERIOD_BITS-1:0]   rd
);

	// Each word holds {period, countdown}
	logic [2*PERIOD_BITS-1:0] mem [NUM_SLOTS];
	logic [2*PERIOD_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

// ===== rtl/pdu_alu.sv =====
module pdu_alu #(
	parameter int PERIOD_BITS = 16
) (
	input  logic                   en,
	input  logic [PERIOD_BITS-1:0] cnt,
	input  logic [PERIOD_BITS-1:0] per,
	output logic                   wr,
	output logic                   fire,
	output logic [PERIOD_BITS-1:0] nxt
);

	logic [PERIOD_BITS-1:0] dec;

	// Count down; on reaching zero, fire and reload from the period
	always_comb begin
		dec  = cnt - 1'b1;
		wr   = en && (cnt != '0);
		fire = wr && (dec == '0);
		nxt  = fire ? per : dec;
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int NUM_SLOTS      = 16;
	localparam int PERIOD_BITS    = 16;
	localparam int RANDOM_PER_MODE = 363;
	localparam int MAX_REPORTS    = 10;
	// Cycles with neither a request nor a response accepted before the run is
	// declared hung.
	localparam int HANG_LIMIT     = 5000;
	// The opcode left unused by the package: the block must treat it as a no-op.
	localparam pdu_pkg::opcode_t OP_UNUSED = 3'd7;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		pdu_pkg::opcode_t opcode;
		pdu_pkg::slot_t   slot;
		pdu_pkg::period_t period;
		idle_mode_t       mode;
	} sched_req_t;

	typedef struct packed {
		pdu_pkg::status_t status;
		logic             run_valid;
		pdu_pkg::slot_t   run_slot;
	} sched_rsp_t;

	logic clk;
	logic arst_n;

	pdu_req_if req();
	pdu_rsp_if rsp();

	periodic_task_dispatcher_unit #(
		.NUM_SLOTS  (NUM_SLOTS),
		.PERIOD_BITS(PERIOD_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Shadow copy of the task table, updated once per accepted request.
	logic                   task_used   [NUM_SLOTS] = '{default: 1'b0};
	logic                   task_on     [NUM_SLOTS] = '{default: 1'b0};
	logic                   task_due    [NUM_SLOTS] = '{default: 1'b0};
	logic [PERIOD_BITS-1:0] task_reload [NUM_SLOTS] = '{default: '0};
	logic [PERIOD_BITS-1:0] task_count  [NUM_SLOTS] = '{default: '0};

	sched_req_t pending_reqs[$];
	sched_rsp_t expected_rsps[$];

	idle_mode_t cur_mode;
	logic       req_fire;
	int         hang_cycles;
	int         mismatches = 0;

	// Apply one request to the shadow table and return the response it earns.
	function automatic sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t             res;
		int                     s;
		logic [PERIOD_BITS-1:0] per;
		logic                   in_range;
		res      = '0;
		res.status = pdu_pkg::STATUS_OK;
		s        = int'(r.slot);
		per      = PERIOD_BITS'(r.period);
		in_range = s < NUM_SLOTS;
		case (r.opcode)
			pdu_pkg::OP_TICK: begin
				for (int k = 0; k < NUM_SLOTS; k++) begin
					if (task_used[k] && task_on[k] && task_count[k] != '0) begin
						task_count[k] = task_count[k] - 1'b1;
						// Fire and reload on reaching zero; a zero period stays parked
						if (task_count[k] == '0) begin
							task_due[k]   = 1'b1;
							task_count[k] = task_reload[k];
						end
					end
				end
			end
			pdu_pkg::OP_ADD: begin
				if (!in_range) begin
					res.status = pdu_pkg::STATUS_RANGE;
				end else if (task_used[s]) begin
					res.status = pdu_pkg::STATUS_BUSY;
				end else begin
					task_used[s]   = 1'b1;
					task_on[s]     = 1'b1;
					task_due[s]    = 1'b0;
					task_reload[s] = per;
					task_count[s]  = per;
				end
			end
			pdu_pkg::OP_REMOVE: begin
				if (in_range) begin
					task_used[s]   = 1'b0;
					task_on[s]     = 1'b0;
					task_due[s]    = 1'b0;
					task_reload[s] = '0;
					task_count[s]  = '0;
				end
			end
			// Enable, disable and set period touch absent slots as well
			pdu_pkg::OP_ENABLE: begin
				if (in_range) task_on[s] = 1'b1;
			end
			pdu_pkg::OP_DISABLE: begin
				if (in_range) task_on[s] = 1'b0;
			end
			pdu_pkg::OP_SETPER: begin
				if (in_range) begin
					task_reload[s] = per;
					task_count[s]  = per;
				end
			end
			pdu_pkg::OP_DISPATCH: begin
				// Lowest slot number wins; clear only the winner's ready flag
				for (int k = 0; k < NUM_SLOTS; k++) begin
					if (!res.run_valid && task_used[k] && task_on[k] && task_due[k]) begin
						task_due[k]   = 1'b0;
						res.run_valid = 1'b1;
						res.run_slot  = pdu_pkg::slot_t'(k);
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Percentage of cycles in which one side holds off, per idling mode.
	function automatic int idle_pct(idle_mode_t mode, logic sender);
		case (mode)
			IDLE_SEND: return sender ? 69 : 0;
			IDLE_RECV: return sender ? 0 : 69;
			IDLE_BOTH: return 33;
			default:   return 0;
		endcase
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	task automatic push_req(pdu_pkg::opcode_t op, int s, int per, idle_mode_t mode);
		sched_req_t r;
		r.opcode = op;
		r.slot   = pdu_pkg::slot_t'(s);
		r.period = pdu_pkg::period_t'(per);
		r.mode   = mode;
		pending_reqs.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Driver: change request and ready at the falling edge only. A request
	// stays up until the monitor has seen it accepted; then either advance to
	// the next pending request or hold off for an idle cycle.
	always @(negedge clk) begin : drive_proc
		logic       nxt_valid;
		sched_req_t item;
		if (!arst_n) begin
			req.valid  <= 1'b0;
			req.opcode <= pdu_pkg::OP_TICK;
			req.slot   <= '0;
			req.period <= '0;
			rsp.ready  <= 1'b0;
			cur_mode   <= IDLE_NONE;
		end else begin
			if (!req.valid || req_fire) begin
				nxt_valid = 1'b0;
				if (pending_reqs.size() != 0 &&
				    $urandom_range(0, 99) >= idle_pct(pending_reqs[0].mode, 1'b1)) begin
					item       = pending_reqs.pop_front();
					nxt_valid  = 1'b1;
					cur_mode   <= item.mode;
					req.opcode <= item.opcode;
					req.slot   <= item.slot;
					req.period <= item.period;
				end
				req.valid <= nxt_valid;
			end
			rsp.ready <= $urandom_range(0, 99) >= idle_pct(cur_mode, 1'b0);
		end
	end

	// Monitor: sample both channels at the rising edge. Check a finished
	// response against the oldest expectation before queueing the new one.
	always @(posedge clk) begin : monitor_proc
		sched_rsp_t want;
		logic       any_fire;
		if (!arst_n) begin
			req_fire    <= 1'b0;
			hang_cycles <= 0;
		end else begin
			any_fire = 1'b0;
			if (rsp.valid && rsp.ready) begin
				any_fire = 1'b1;
				if (expected_rsps.size() == 0) begin
					report_mismatch("response with none outstanding, status", -1,
					                int'(rsp.status));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", int'(want.status), int'(rsp.status));
					if (rsp.run_valid !== want.run_valid)
						report_mismatch("run_valid", int'(want.run_valid), int'(rsp.run_valid));
					if (rsp.run_slot !== want.run_slot)
						report_mismatch("run_slot", int'(want.run_slot), int'(rsp.run_slot));
				end
			end
			if (req.valid && req.ready) begin
				any_fire = 1'b1;
				expected_rsps.push_back(schedule_step('{req.opcode, req.slot, req.period,
				                                        IDLE_NONE}));
			end
			req_fire <= req.valid && req.ready;
			if (any_fire) begin
				hang_cycles <= 0;
			end else if (hang_cycles + 1 >= HANG_LIMIT) begin
				$display("[periodic_task_dispatcher_unit] ERROR");
				$finish;
			end else begin
				hang_cycles <= hang_cycles + 1;
			end
		end
	end

	initial begin : stimulus_proc
		int               r;
		int               per;
		pdu_pkg::opcode_t op;
		idle_mode_t       mode;

		arst_n = 1'b0;

		// Directed part: empty table, field extremes, busy add, zero period,
		// priority with a disabled winner, absent-slot edits, unused opcode.
		push_req(pdu_pkg::OP_DISPATCH, 9, 'hABCD, IDLE_NONE);
		push_req(pdu_pkg::OP_TICK, 15, 'hFFFF, IDLE_NONE);
		push_req(pdu_pkg::OP_ADD, 0, 1, IDLE_NONE);
		push_req(pdu_pkg::OP_ADD, 15, 'hFFFF, IDLE_NONE);
		push_req(pdu_pkg::OP_ADD, 0, 5, IDLE_NONE);
		push_req(pdu_pkg::OP_ADD, 7, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_TICK, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_TICK, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_DISPATCH, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_DISPATCH, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_ADD, 3, 2, IDLE_NONE);
		push_req(pdu_pkg::OP_TICK, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_TICK, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_DISABLE, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_DISPATCH, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_ENABLE, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_DISPATCH, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_SETPER, 9, 1, IDLE_NONE);
		push_req(pdu_pkg::OP_ENABLE, 9, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_REMOVE, 0, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_REMOVE, 12, 'hFFFF, IDLE_NONE);
		push_req(OP_UNUSED, 15, 'hFFFF, IDLE_NONE);
		push_req(pdu_pkg::OP_DISABLE, 15, 0, IDLE_NONE);
		push_req(pdu_pkg::OP_SETPER, 15, 1, IDLE_NONE);
		push_req(pdu_pkg::OP_TICK, 0, 0, IDLE_NONE);

		// Random part: tick-heavy mix so tasks keep firing and dispatches find
		// work; mostly short periods, some wide ones to toggle every bit.
		for (int m = 0; m < 4; m++) begin
			mode = idle_mode_t'(m);
			for (int i = 0; i < RANDOM_PER_MODE; i++) begin
				r = $urandom_range(0, 99);
				if (r < 40)      op = pdu_pkg::OP_TICK;
				else if (r < 70) op = pdu_pkg::OP_DISPATCH;
				else if (r < 80) op = pdu_pkg::OP_ADD;
				else if (r < 85) op = pdu_pkg::OP_REMOVE;
				else if (r < 89) op = pdu_pkg::OP_ENABLE;
				else if (r < 93) op = pdu_pkg::OP_DISABLE;
				else if (r < 98) op = pdu_pkg::OP_SETPER;
				else             op = OP_UNUSED;
				r = $urandom_range(0, 99);
				if (r < 70)      per = $urandom_range(0, 6);
				else if (r < 90) per = $urandom_range(0, 40);
				else             per = $urandom_range(0, 65535);
				push_req(op, $urandom_range(0, NUM_SLOTS - 1), per, mode);
			end
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Drain: every request sent and every response back, then let any late
		// extra response surface before judging.
		while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (2 * NUM_SLOTS + 8) @(posedge clk);

		if (mismatches == 0) begin
			$display("[periodic_task_dispatcher_unit] OK");
		end else begin
			$display("[periodic_task_dispatcher_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pdu_pkg.sv
rtl/pdu_req_if.sv
rtl/pdu_rsp_if.sv
rtl/pdu_cnt_mem.sv
rtl/pdu_alu.sv
rtl/periodic_task_dispatcher_unit.sv
dv/testbench.sv
